// File: rtl/sem_pkg.sv
// package for the semaphore table: sizes, command, status and kind codes,
// sequencer states and the structs shared by the rtl modules
// no dependencies
package sem_pkg;

   localparam int NUM_SEMAS  = 16;
   localparam int WAIT_DEPTH = 8;
   localparam int COUNT_BITS = 16;

   localparam int SLOT_BITS  = (NUM_SEMAS > 1) ? $clog2(NUM_SEMAS) : 1;
   localparam int POS_BITS   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int WCNT_BITS  = $clog2(WAIT_DEPTH + 1);
   localparam int RAM_DEPTH  = NUM_SEMAS * WAIT_DEPTH;
   localparam int ADDR_BITS  = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
   localparam int ALU_BITS   = (COUNT_BITS > 7) ? COUNT_BITS : 7;
   localparam int ENTRY_BITS = 15;

   // command codes
   localparam logic [2:0] CMD_CREATE = 3'd0;
   localparam logic [2:0] CMD_DELETE = 3'd1;
   localparam logic [2:0] CMD_SIGNAL = 3'd2;
   localparam logic [2:0] CMD_WAIT   = 3'd3;
   localparam logic [2:0] CMD_POLL   = 3'd4;
   localparam logic [2:0] CMD_STATUS = 3'd5;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_CONTEXT = 3'd1;
   localparam logic [2:0] ST_ATTR    = 3'd2;
   localparam logic [2:0] ST_NOSLOT  = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;
   localparam logic [2:0] ST_OVF     = 3'd5;
   localparam logic [2:0] ST_ZERO    = 3'd6;
   localparam logic [2:0] ST_FULL    = 3'd7;

   // wake kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_SIGNAL = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_INS_RD,
      S_INS_CMP,
      S_INS_PUT,
      S_POP_RD,
      S_POP_USE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [6:0] pri;
      logic [7:0] tid;
   } entry_type;

   typedef struct packed {
      logic [31:0] info_option;
      logic [3:0]  info_waiters;
      logic [15:0] info_initial;
      logic [15:0] info_max;
      logic [15:0] info_count;
      logic [2:0]  info_attr;
      logic [7:0]  woken_thread;
      logic [1:0]  woken_kind;
      logic        blocked;
      logic [3:0]  handle;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      logic                ge;
      logic                gt;
      logic                zero;
      logic [ALU_BITS-1:0] inc;
      logic [ALU_BITS-1:0] dec;
   } alu_out_type;

endpackage

// File: rtl/sem_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/sem_alu.sv
// shared compare, increment and decrement unit used by the exec and insert-compare steps
// depends on sem_pkg
module sem_alu
   import sem_pkg::*;
(
   input  logic [ALU_BITS-1:0] a,
   input  logic [ALU_BITS-1:0] b,
   output alu_out_type         res
);

   always_comb begin
      res.ge   = (a >= b);
      res.gt   = (a > b);
      res.zero = (a == '0);
      res.inc  = a + ALU_BITS'(1);
      res.dec  = a - ALU_BITS'(1);
   end

endmodule

// File: rtl/semaphore_table_with_wait_queues_top.sv
// top level of the semaphore table: request latch, sequencer, slot table
// depends on sem_pkg, sem_alu and sem_ram
// sequencing: each command passes through an exec step to its result beat; a signal
//   that wakes a waiter first reads it (pop read, pop use); a priority wait does a
//   read and a compare per waiter it moves, plus one unless it moves them all, and
//   a put step if it moves them all; delete gives one beat per waiter, each after
//   its own pop read and pop use once the previous one is taken
// throughput: one command at a time, set by the single sequencer and the one
//   port pair of the waiter ram; req_tready is high only when idle
// reset: synchronous, active high; clears the slot-in-use bits and the sequencer
module semaphore_table_with_wait_queues_top
   import sem_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata from bit 0: in_interrupt, sema_id, thread_id, thread_priority,
   // create_attr, create_initial, create_max, create_option
   input  logic [87:0]  req_tdata,
   // tuser: cmd
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata from bit 0: status, handle, blocked, woken_kind, woken_thread,
   // info_attr, info_count, info_max, info_initial, info_waiters, info_option, zero pad
   output logic [111:0] rsp_tdata,
   output logic         rsp_tlast
);

   state_type state_ff, state_in;

   // latched request beat
   logic [2:0]  cmd_ff;
   logic        intr_ff;
   logic [3:0]  id_ff;
   logic [7:0]  tid_ff;
   logic [6:0]  pri_ff;
   logic [3:0]  attr_ff;
   logic [15:0] init_ff;
   logic [15:0] max_ff;
   logic [31:0] opt_ff;

   // slot table
   logic                  used_ff  [NUM_SEMAS];
   logic [COUNT_BITS-1:0] count_ff [NUM_SEMAS];
   logic [COUNT_BITS-1:0] smax_ff  [NUM_SEMAS];
   logic [COUNT_BITS-1:0] sinit_ff [NUM_SEMAS];
   logic [2:0]            sattr_ff [NUM_SEMAS];
   logic [31:0]           sopt_ff  [NUM_SEMAS];
   logic [WCNT_BITS-1:0]  total_ff [NUM_SEMAS];
   logic [POS_BITS-1:0]   head_ff  [NUM_SEMAS];

   // sequencer work registers
   logic [WCNT_BITS-1:0] idx_ff, idx_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 last_ff, last_in;

   // table write strobes
   logic                  create_we;
   logic                  cnt_we;
   logic [COUNT_BITS-1:0] cnt_wd;
   logic                  tot_we;
   logic [WCNT_BITS-1:0]  tot_wd;
   logic                  head_we;
   logic [POS_BITS-1:0]   head_wd;
   logic                  used_clr;

   // waiter ram
   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr, ram_raddr;
   entry_type             ram_wdata, ram_rdata;

   // decode of the addressed slot
   logic [SLOT_BITS-1:0]  cur;
   logic [SLOT_BITS-1:0]  free_slot;
   logic                  any_free;
   logic                  id_bad, bad_ctx, bad_cmd, prio_mode;
   logic [COUNT_BITS-1:0] cnt;
   logic [WCNT_BITS-1:0]  tot;
   logic [POS_BITS-1:0]   hd;
   entry_type             new_entry;

   logic [ALU_BITS-1:0]   alu_a, alu_b;
   alu_out_type           alu_res;

   // queue position relative to head, wrapped inside the slot's row
   function automatic logic [POS_BITS-1:0] qpos(input logic [POS_BITS-1:0] h,
                                                input logic [WCNT_BITS-1:0] k);
      logic [WCNT_BITS+POS_BITS-1:0] s;
      s = (WCNT_BITS+POS_BITS)'(h) + (WCNT_BITS+POS_BITS)'(k);
      if (s >= (WCNT_BITS+POS_BITS)'(WAIT_DEPTH)) begin
         s = s - (WCNT_BITS+POS_BITS)'(WAIT_DEPTH);
      end
      return POS_BITS'(s);
   endfunction

   function automatic logic [ADDR_BITS-1:0] qaddr(input logic [SLOT_BITS-1:0] sl,
                                                  input logic [POS_BITS-1:0] p);
      return ADDR_BITS'(ADDR_BITS'(sl) * WAIT_DEPTH) + ADDR_BITS'(p);
   endfunction

   assign cur       = SLOT_BITS'(id_ff);
   assign cnt       = count_ff[cur];
   assign tot       = total_ff[cur];
   assign hd        = head_ff[cur];
   assign prio_mode = sattr_ff[cur][1];
   assign id_bad    = !(32'(id_ff) < NUM_SEMAS) || !used_ff[cur];
   assign bad_cmd   = (cmd_ff > CMD_STATUS);
   assign bad_ctx   = intr_ff && (cmd_ff != CMD_SIGNAL) && (cmd_ff != CMD_STATUS);
   assign new_entry = '{pri: pri_ff, tid: tid_ff};

   // lowest free slot
   always_comb begin
      free_slot = '0;
      any_free  = 1'b0;
      for (int i = NUM_SEMAS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_slot = SLOT_BITS'(i);
            any_free  = 1'b1;
         end
      end
   end

   // shared unit: priority compare while inserting, count arithmetic otherwise
   always_comb begin
      if (state_ff == S_INS_CMP) begin
         alu_a = ALU_BITS'(ram_rdata.pri);
         alu_b = ALU_BITS'(pri_ff);
      end else begin
         alu_a = ALU_BITS'(cnt);
         alu_b = ALU_BITS'(smax_ff[cur]);
      end
   end

   sem_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   sem_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (bad_cmd) begin
               state_in = S_IDLE;
            end else if (bad_ctx || cmd_ff == CMD_CREATE || id_bad) begin
               state_in = S_OUT;
            end else if ((cmd_ff == CMD_DELETE || cmd_ff == CMD_SIGNAL) && tot != '0) begin
               state_in = S_POP_RD;
            end else if (cmd_ff == CMD_WAIT && alu_res.zero && prio_mode && tot != '0
                         && 32'(tot) < WAIT_DEPTH) begin
               state_in = S_INS_RD;
            end else begin
               state_in = S_OUT;
            end
         end
         S_INS_RD:  state_in = S_INS_CMP;
         S_INS_CMP: begin
            if (!alu_res.gt) begin
               state_in = S_OUT;
            end else if (idx_ff == WCNT_BITS'(1)) begin
               state_in = S_INS_PUT;
            end else begin
               state_in = S_INS_RD;
            end
         end
         S_INS_PUT: state_in = S_OUT;
         S_POP_RD:  state_in = S_POP_USE;
         S_POP_USE: state_in = S_OUT;
         S_OUT: begin
            if (rsp_tready) begin
               state_in = (cmd_ff == CMD_DELETE && !last_ff) ? S_POP_RD : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      rsp_in    = rsp_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      create_we = 1'b0;
      cnt_we    = 1'b0;
      cnt_wd    = cnt;
      tot_we    = 1'b0;
      tot_wd    = tot;
      head_we   = 1'b0;
      head_wd   = hd;
      used_clr  = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = qaddr(cur, qpos(hd, idx_ff));
      ram_wdata = new_entry;
      ram_raddr = qaddr(cur, hd);
      case (state_ff)
         S_EXEC: begin
            rsp_in  = '0;
            last_in = 1'b1;
            idx_in  = tot;
            if (bad_ctx) begin
               rsp_in.status = ST_CONTEXT;
            end else if (cmd_ff == CMD_CREATE) begin
               if (attr_ff[3]) begin
                  rsp_in.status = ST_ATTR;
               end else if (!any_free) begin
                  rsp_in.status = ST_NOSLOT;
               end else begin
                  create_we     = 1'b1;
                  rsp_in.handle = 4'(free_slot);
               end
            end else if (id_bad) begin
               rsp_in.status = ST_UNKNOWN;
            end else begin
               case (cmd_ff)
                  CMD_DELETE: begin
                     if (tot == '0) used_clr = 1'b1;
                  end
                  CMD_SIGNAL: begin
                     if (tot == '0) begin
                        if (alu_res.ge) begin
                           rsp_in.status = ST_OVF;
                        end else begin
                           cnt_we = 1'b1;
                           cnt_wd = COUNT_BITS'(alu_res.inc);
                        end
                     end
                  end
                  CMD_WAIT: begin
                     if (!alu_res.zero) begin
                        cnt_we = 1'b1;
                        cnt_wd = COUNT_BITS'(alu_res.dec);
                     end else if (!(32'(tot) < WAIT_DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        rsp_in.blocked = 1'b1;
                        if (!prio_mode || tot == '0) begin
                           // append at the tail
                           ram_we    = 1'b1;
                           ram_waddr = qaddr(cur, qpos(hd, tot));
                           tot_we    = 1'b1;
                           tot_wd    = tot + WCNT_BITS'(1);
                        end
                     end
                  end
                  CMD_POLL: begin
                     if (alu_res.zero) begin
                        rsp_in.status = ST_ZERO;
                     end else begin
                        cnt_we = 1'b1;
                        cnt_wd = COUNT_BITS'(alu_res.dec);
                     end
                  end
                  CMD_STATUS: begin
                     rsp_in.info_attr    = sattr_ff[cur];
                     rsp_in.info_count   = 16'(cnt);
                     rsp_in.info_max     = 16'(smax_ff[cur]);
                     rsp_in.info_initial = 16'(sinit_ff[cur]);
                     rsp_in.info_waiters = 4'(tot);
                     rsp_in.info_option  = sopt_ff[cur];
                  end
                  default: begin
                     rsp_in = '0;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            ram_raddr = qaddr(cur, qpos(hd, idx_ff - WCNT_BITS'(1)));
         end
         S_INS_CMP: begin
            ram_we = 1'b1;
            if (alu_res.gt) begin
               // move the higher priority value one place toward the tail
               ram_wdata = ram_rdata;
               idx_in    = idx_ff - WCNT_BITS'(1);
            end else begin
               tot_we = 1'b1;
               tot_wd = tot + WCNT_BITS'(1);
            end
         end
         S_INS_PUT: begin
            ram_we = 1'b1;
            tot_we = 1'b1;
            tot_wd = tot + WCNT_BITS'(1);
         end
         S_POP_USE: begin
            rsp_in              = '0;
            rsp_in.woken_thread = ram_rdata.tid;
            rsp_in.woken_kind   = (cmd_ff == CMD_DELETE) ? KIND_DELETE : KIND_SIGNAL;
            last_in             = (cmd_ff != CMD_DELETE) || (tot == WCNT_BITS'(1));
            head_we             = 1'b1;
            head_wd             = qpos(hd, WCNT_BITS'(1));
            tot_we              = 1'b1;
            tot_wd              = tot - WCNT_BITS'(1);
            if (cmd_ff == CMD_DELETE && tot == WCNT_BITS'(1)) used_clr = 1'b1;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < NUM_SEMAS; i++) used_ff[i] <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (create_we) used_ff[free_slot] <= 1'b1;
         if (used_clr)  used_ff[cur] <= 1'b0;
      end
   end

   // payload: request latch, result register and slot fields
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         cmd_ff  <= req_tuser;
         intr_ff <= req_tdata[0];
         id_ff   <= req_tdata[4:1];
         tid_ff  <= req_tdata[12:5];
         pri_ff  <= req_tdata[19:13];
         attr_ff <= req_tdata[23:20];
         init_ff <= req_tdata[39:24];
         max_ff  <= req_tdata[55:40];
         opt_ff  <= req_tdata[87:56];
      end
      rsp_ff  <= rsp_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
      if (create_we) begin
         count_ff[free_slot] <= COUNT_BITS'(init_ff);
         sinit_ff[free_slot] <= COUNT_BITS'(init_ff);
         smax_ff[free_slot]  <= COUNT_BITS'(max_ff);
         sattr_ff[free_slot] <= attr_ff[2:0];
         sopt_ff[free_slot]  <= opt_ff;
         total_ff[free_slot] <= '0;
         head_ff[free_slot]  <= '0;
      end
      if (cnt_we)  count_ff[cur] <= cnt_wd;
      if (tot_we)  total_ff[cur] <= tot_wd;
      if (head_we) head_ff[cur]  <= head_wd;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {7'd0, rsp_ff};
   assign rsp_tlast  = last_ff;

   // a result is never shown while a new request can be taken
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("result beat overlaps request acceptance");

   // each priority compare comes in the cycle after a ram read
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS_CMP |-> $past(state_ff) == S_INS_RD)
      else $error("insert compare without preceding read");

   // only delete produces beats that are not the last of a command
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (cmd_ff == CMD_DELETE && rsp_ff.woken_kind == KIND_DELETE))
      else $error("non-final beat outside delete");

   // the insert index never runs past the queue
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS_RD |-> (idx_ff != '0 && 32'(idx_ff) < WAIT_DEPTH))
      else $error("insert index out of range");

endmodule

// File: test/semaphore_table_with_wait_queues_top_test.sv
// self-checking testbench for the semaphore table: directed and random commands,
// results predicted in the bench and compared beat by beat
// depends on sem_pkg and semaphore_table_with_wait_queues_top
`timescale 1ns / 1ps

module semaphore_table_with_wait_queues_top_test;
   import sem_pkg::*;

   typedef struct {
      logic [2:0]  cmd;
      logic        intr;
      logic [3:0]  id;
      logic [7:0]  tid;
      logic [6:0]  pri;
      logic [3:0]  attr;
      logic [15:0] initv;
      logic [15:0] maxv;
      logic [31:0] opt;
      bit          drain;      // not a command: sender waits for all results
   } sem_cmd_type;

   typedef struct {
      rsp_type     r;
      logic        last;
   } sem_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [87:0]  req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;
   logic         rsp_tlast;

   semaphore_table_with_wait_queues_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   // shadow copy of the semaphore table
   bit          sh_used  [NUM_SEMAS];
   logic [15:0] sh_count [NUM_SEMAS];
   logic [15:0] sh_max   [NUM_SEMAS];
   logic [15:0] sh_init  [NUM_SEMAS];
   logic [2:0]  sh_attr  [NUM_SEMAS];
   logic [31:0] sh_opt   [NUM_SEMAS];
   int          sh_nwait [NUM_SEMAS];
   entry_type   sh_queue [NUM_SEMAS][WAIT_DEPTH];

   sem_cmd_type    cmd_queue[$];
   sem_result_type awaited[$];
   sem_cmd_type    cur;
   int          fail_count = 0;
   int          gap = 0;
   int          stall = 0;
   int          hold = 0;
   bit          hold_done = 0;
   int          rsp_beats = 0;
   int          idle_cycles = 0;

   // no idling once the stimulus is nearly used up
   wire tail = cmd_queue.size() < 40;

   function automatic void push_result(logic [2:0] st, logic lst, logic [1:0] kind = KIND_NONE,
                                       logic [7:0] thr = 8'd0);
      sem_result_type e;
      e.r = '0;
      e.r.status = st;
      e.r.woken_kind = kind;
      e.r.woken_thread = thr;
      e.last = lst;
      awaited.push_back(e);
   endfunction

   function automatic entry_type pop_waiter(int s);
      entry_type e;
      e = sh_queue[s][0];
      for (int i = 1; i < sh_nwait[s]; i++) sh_queue[s][i-1] = sh_queue[s][i];
      sh_nwait[s]--;
      return e;
   endfunction

   // predicts the result beats of one command and updates the shadow table
   function automatic void predict_command(sem_cmd_type c);
      int s;
      int pos;
      entry_type e;
      sem_result_type r;
      if (c.cmd > CMD_STATUS) return;
      if (c.intr && c.cmd != CMD_SIGNAL && c.cmd != CMD_STATUS) begin
         push_result(ST_CONTEXT, 1);
         return;
      end
      if (c.cmd == CMD_CREATE) begin
         if (c.attr[3]) begin
            push_result(ST_ATTR, 1);
            return;
         end
         for (s = 0; s < NUM_SEMAS; s++) if (!sh_used[s]) break;
         if (s >= NUM_SEMAS) begin
            push_result(ST_NOSLOT, 1);
            return;
         end
         sh_used[s] = 1;
         sh_attr[s] = c.attr[2:0];
         sh_opt[s] = c.opt;
         sh_count[s] = c.initv;
         sh_init[s] = c.initv;
         sh_max[s] = c.maxv;
         sh_nwait[s] = 0;
         push_result(ST_OK, 1);
         awaited[$].r.handle = s[3:0];
         return;
      end
      s = c.id;
      if (!sh_used[s]) begin
         push_result(ST_UNKNOWN, 1);
         return;
      end
      case (c.cmd)
         CMD_DELETE: begin
            if (sh_nwait[s] == 0) push_result(ST_OK, 1);
            while (sh_nwait[s] > 0) begin
               e = pop_waiter(s);
               push_result(ST_OK, sh_nwait[s] == 0, KIND_DELETE, e.tid);
            end
            sh_used[s] = 0;
         end
         CMD_SIGNAL: begin
            if (sh_nwait[s] > 0) begin
               e = pop_waiter(s);
               push_result(ST_OK, 1, KIND_SIGNAL, e.tid);
            end else if (sh_count[s] >= sh_max[s]) push_result(ST_OVF, 1);
            else begin
               sh_count[s]++;
               push_result(ST_OK, 1);
            end
         end
         CMD_WAIT: begin
            if (sh_count[s] != 0) begin
               sh_count[s]--;
               push_result(ST_OK, 1);
            end else if (sh_nwait[s] >= WAIT_DEPTH) push_result(ST_FULL, 1);
            else begin
               // priority mode: after all waiters of lower or equal value
               pos = sh_nwait[s];
               if (sh_attr[s][1])
                  for (int i = 0; i < sh_nwait[s]; i++)
                     if (sh_queue[s][i].pri > c.pri) begin
                        pos = i;
                        break;
                     end
               for (int i = sh_nwait[s]; i > pos; i--) sh_queue[s][i] = sh_queue[s][i-1];
               sh_queue[s][pos].tid = c.tid;
               sh_queue[s][pos].pri = c.pri;
               sh_nwait[s]++;
               push_result(ST_OK, 1);
               awaited[$].r.blocked = 1'b1;
            end
         end
         CMD_POLL: begin
            if (sh_count[s] == 0) push_result(ST_ZERO, 1);
            else begin
               sh_count[s]--;
               push_result(ST_OK, 1);
            end
         end
         default: begin
            r.r = '0;
            r.r.info_attr = sh_attr[s];
            r.r.info_count = sh_count[s];
            r.r.info_max = sh_max[s];
            r.r.info_initial = sh_init[s];
            r.r.info_waiters = sh_nwait[s][3:0];
            r.r.info_option = sh_opt[s];
            r.last = 1;
            awaited.push_back(r);
         end
      endcase
   endfunction

   function automatic void add_cmd(logic [2:0] cmd, logic [3:0] id = 0, logic [7:0] tid = 0,
                                   logic [6:0] pri = 0, logic intr = 0, logic [3:0] attr = 0,
                                   logic [15:0] iv = 0, logic [15:0] mv = 0,
                                   logic [31:0] opt = 0);
      sem_cmd_type c;
      c.cmd = cmd; c.id = id; c.tid = tid; c.pri = pri; c.intr = intr;
      c.attr = attr; c.initv = iv; c.maxv = mv; c.opt = opt; c.drain = 0;
      cmd_queue.push_back(c);
   endfunction

   // random command, weighted toward signal and wait on small counts
   function automatic void add_random_cmd();
      int     w;
      logic [2:0] cmd;
      logic [3:0] attr;
      logic [15:0] iv, mv;
      w = $urandom_range(0, 99);
      if (w < 16) cmd = CMD_CREATE;
      else if (w < 24) cmd = CMD_DELETE;
      else if (w < 46) cmd = CMD_SIGNAL;
      else if (w < 72) cmd = CMD_WAIT;
      else if (w < 83) cmd = CMD_POLL;
      else if (w < 97) cmd = CMD_STATUS;
      else cmd = 3'($urandom_range(6, 7));   // undefined, ignored by the block
      attr = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7));
      if ($urandom_range(0, 7) == 0) begin
         iv = 16'($urandom);
         mv = 16'($urandom);
      end else begin
         iv = 16'($urandom_range(0, 2));
         mv = 16'($urandom_range(0, 3));
      end
      add_cmd(cmd, 4'($urandom), 8'($urandom), 7'($urandom),
              $urandom_range(0, 11) == 0, attr, iv, mv, $urandom);
   endfunction

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
         gap <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_command(cur);
         if (!req_tvalid || req_tready) begin
            if (gap > 0) begin
               gap <= gap - 1;
               req_tvalid <= 1'b0;
            end else if (cmd_queue.size() > 0 && cmd_queue[0].drain) begin
               // hold off until every pending result has been taken
               if (awaited.size() == 0) void'(cmd_queue.pop_front());
               req_tvalid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
               cur = cmd_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur.cmd;
               req_tdata <= {cur.opt, cur.maxv, cur.initv, cur.attr, cur.pri, cur.tid,
                             cur.id, cur.intr};
               if (!tail && $urandom_range(0, 3) == 0) gap <= $urandom_range(1, 5);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      rsp_type act;
      sem_result_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats++;
            act = rsp_tdata[$bits(rsp_type)-1:0];
            if (awaited.size() == 0) begin
               $error("result beat with nothing expected: 0x%0h", rsp_tdata);
               fail_count++;
            end else begin
               e = awaited.pop_front();
               check_field("status", e.r.status, act.status);
               check_field("handle", e.r.handle, act.handle);
               check_field("blocked", e.r.blocked, act.blocked);
               check_field("woken_kind", e.r.woken_kind, act.woken_kind);
               check_field("woken_thread", e.r.woken_thread, act.woken_thread);
               check_field("info_attr", e.r.info_attr, act.info_attr);
               check_field("info_count", e.r.info_count, act.info_count);
               check_field("info_max", e.r.info_max, act.info_max);
               check_field("info_initial", e.r.info_initial, act.info_initial);
               check_field("info_waiters", e.r.info_waiters, act.info_waiters);
               check_field("info_option", e.r.info_option, act.info_option);
               check_field("last", e.last, rsp_tlast);
            end
         end
         if (hold > 0) begin
            hold <= hold - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && rsp_beats >= 150) begin
            // long back-pressure so the block stalls its input
            hold <= 80;
            hold_done <= 1'b1;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall <= stall - 1;
            rsp_tready <= 1'b0;
         end else if (!tail && $urandom_range(0, 4) == 0) begin
            stall <= $urandom_range(1, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
         $display("** semaphore_table_with_wait_queues_top: FAILED **");
         $finish;
      end
   end

   initial begin
      sem_cmd_type d;
      reset = 1'b1;
      // directed part
      add_cmd(CMD_CREATE, 0, 0, 0, 0, 4'd0, 16'd0, 16'd2, 32'h0);         // slot 0 fifo
      add_cmd(CMD_CREATE, 0, 0, 0, 0, 4'd7, 16'd0, 16'hffff, 32'hffffffff); // slot 1 priority
      add_cmd(CMD_CREATE, 0, 0, 0, 0, 4'd8, 16'd1, 16'd1, 32'h1);        // bad attribute
      add_cmd(CMD_CREATE, 0, 0, 0, 1);                                    // interrupt context
      add_cmd(CMD_STATUS, 0, 0, 0, 1);                                    // allowed in interrupt
      add_cmd(CMD_POLL, 0);                                               // zero
      add_cmd(CMD_WAIT, 0, 8'd1, 7'd5);
      add_cmd(CMD_WAIT, 0, 8'd255, 7'd127);
      add_cmd(CMD_SIGNAL, 0, 0, 0, 1);                                    // wakes thread 1
      add_cmd(CMD_SIGNAL, 0);                                             // wakes thread 255
      add_cmd(CMD_SIGNAL, 0);
      add_cmd(CMD_SIGNAL, 0);
      add_cmd(CMD_SIGNAL, 0);                                             // overflow
      add_cmd(CMD_POLL, 0);
      add_cmd(CMD_WAIT, 0);
      add_cmd(CMD_WAIT, 1, 8'h10, 7'd50);
      add_cmd(CMD_WAIT, 1, 8'h11, 7'd10);
      add_cmd(CMD_WAIT, 1, 8'h12, 7'd50);                                 // equal priority
      add_cmd(CMD_WAIT, 1, 8'h13, 7'd0);
      add_cmd(CMD_STATUS, 1);
      add_cmd(CMD_DELETE, 1);                                             // four released
      add_cmd(CMD_STATUS, 1);                                             // unknown id
      add_cmd(CMD_CREATE, 0, 0, 0, 0, 4'd1, 16'd5, 16'd3, 32'h5a5a5a5a);  // initial above max
      add_cmd(CMD_SIGNAL, 1);
      add_cmd(3'd6);
      // random part, one pause for the sender partway through
      for (int i = 0; i < 320; i++) begin
         if (i == 160) begin
            d.drain = 1;
            cmd_queue.push_back(d);
         end
         add_random_cmd();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (cmd_queue.size() > 0 || req_tvalid || awaited.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0 && awaited.size() == 0) begin
         $display("** semaphore_table_with_wait_queues_top: PASSED **");
      end else begin
         $display("** semaphore_table_with_wait_queues_top: FAILED **");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/sem_pkg.sv
rtl/sem_ram.sv
rtl/sem_alu.sv
rtl/semaphore_table_with_wait_queues_top.sv
test/semaphore_table_with_wait_queues_top_test.sv
